@@ design/udpdmx_pkg.sv @@
package udpdmx_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam logic [15:0] HDR_BYTES = 16'd8;

  typedef enum logic [1:0] {
    FUNC_OPEN    = 2'd0,
    FUNC_DELIVER = 2'd1,
    FUNC_SEND    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RESERVED = 3'd1,
    ST_FULL     = 3'd2,
    ST_SHORT    = 3'd3,
    ST_REFUSED  = 3'd4,
    ST_NOT_OPEN = 3'd5
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] local_addr;
    logic [15:0] local_port;
    logic [31:0] remote_addr;
    logic [15:0] remote_port;
    logic [15:0] byte_count;
    logic [15:0] header_length;
    logic [5:0]  target_slot;
  } item_t;

  typedef struct packed {
    logic        vld;
    logic        found;
    logic [31:0] addr;
    logic [15:0] port;
  } hop_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot_number;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] udp_length;
  } res_t;

endpackage

@@ design/udpdmx_cell.sv @@
module udpdmx_cell #(
  parameter int unsigned SLOTS = udpdmx_pkg::SLOTS_DEF,
  parameter int unsigned IDX   = 0,
  parameter int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  udpdmx_pkg::item_t  item_i,
  input  udpdmx_pkg::hop_t   hop_i,
  input  logic [IW-1:0]      slot_i,
  output udpdmx_pkg::hop_t   hop_o,
  output logic [IW-1:0]      slot_o
);
  import udpdmx_pkg::*;

  localparam int unsigned CW = (IW > 6) ? IW : 6;

  logic [31:0]   addr_q;
  logic [15:0]   port_q;
  logic          wr;
  hop_t          hop_d, hop_q;
  logic [IW-1:0] slot_d, slot_q;

  always_comb begin
    hop_d  = hop_i;
    slot_d = slot_i;
    wr     = 1'b0;
    if (hop_i.vld && !hop_i.found) begin
      unique case (item_i.func)
        FUNC_OPEN: begin
          if (port_q == 16'd0) begin
            wr          = 1'b1;
            hop_d.found = 1'b1;
            slot_d      = IW'(IDX);
          end
        end
        FUNC_DELIVER: begin
          if (port_q != 16'd0 && port_q == item_i.local_port &&
              addr_q == item_i.local_addr) begin
            hop_d.found = 1'b1;
            slot_d      = IW'(IDX);
          end
        end
        FUNC_SEND: begin
          if (CW'(item_i.target_slot) == CW'(IDX)) begin
            hop_d.found = 1'b1;
            hop_d.addr  = addr_q;
            hop_d.port  = port_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      port_q <= '0;
      hop_q  <= '0;
    end else begin
      hop_q <= hop_d;
      if (wr) begin
        addr_q <= item_i.local_addr;
        port_q <= item_i.local_port;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign hop_o  = hop_q;
  assign slot_o = slot_q;

endmodule

@@ design/udp_port_demux_table.sv @@
// Channel  | Dir | tdata (low bit first)                              | tuser
// s_axis   | in  | local_addr, local_port, remote_addr, remote_port,  | func
//          |     | byte_count, header_length, target_slot, pad to 136 |
// m_axis   | out | slot_number, source_addr, dest_addr, source_port,  | status
//          |     | dest_port, udp_length, checksum, pad to 136        |
//
// An open, deliver or send word walks the row of slot cells, one cell per cycle, and the
// next word is not accepted until that walk has finished and its result has moved on.
// A reserved port or a short datagram gets its result without a walk; an unused function code gives no result.
// Reset frees every slot at once; there is no clearing pass.
// The input side takes a new word while a finished result waits on the output side.
module udp_port_demux_table #(
  parameter int unsigned SLOTS = udpdmx_pkg::SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // local_addr, local_port, remote_addr, remote_port, byte_count, header_length,
  // target_slot, zero pad
  input  logic [135:0] s_axis_tdata,
  // func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot_number, source_addr, dest_addr, source_port, dest_port, udp_length,
  // checksum, zero pad
  output logic [135:0] m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser
);
  import udpdmx_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  item_t         item_in, item_q;
  hop_t          hop_w  [SLOTS+1];
  logic [IW-1:0] slot_w [SLOTS+1];
  hop_t          hop_end;
  logic          acc;
  logic          busy_d, busy_q, inj_q;
  logic          pend_vld_d, pend_vld_q, out_vld_d, out_vld_q;
  res_t          pend_d, pend_q, out_d, out_q, imm_res, walk_res;
  logic          imm;

  assign item_in.func          = func_e'(s_axis_tuser);
  assign item_in.local_addr    = s_axis_tdata[31:0];
  assign item_in.local_port    = s_axis_tdata[47:32];
  assign item_in.remote_addr   = s_axis_tdata[79:48];
  assign item_in.remote_port   = s_axis_tdata[95:80];
  assign item_in.byte_count    = s_axis_tdata[111:96];
  assign item_in.header_length = s_axis_tdata[127:112];
  assign item_in.target_slot   = s_axis_tdata[133:128];

  assign s_axis_tready = !busy_q && !pend_vld_q;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign hop_w[0]  = '{vld: inj_q, found: 1'b0, addr: 32'd0, port: 16'd0};
  assign slot_w[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    udpdmx_cell #(
      .SLOTS (SLOTS),
      .IDX   (g),
      .IW    (IW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (item_q),
      .hop_i  (hop_w[g]),
      .slot_i (slot_w[g]),
      .hop_o  (hop_w[g+1]),
      .slot_o (slot_w[g+1])
    );
  end

  assign hop_end = hop_w[SLOTS];

  always_comb begin
    imm     = 1'b0;
    imm_res = '0;
    if (item_in.func == FUNC_OPEN && item_in.local_port == 16'd0) begin
      imm            = 1'b1;
      imm_res.status = ST_RESERVED;
    end else if (item_in.func == FUNC_DELIVER &&
                 (item_in.byte_count < HDR_BYTES || item_in.header_length < HDR_BYTES)) begin
      imm            = 1'b1;
      imm_res.status = ST_SHORT;
    end
  end

  always_comb begin
    walk_res = '0;
    unique case (item_q.func)
      FUNC_OPEN: begin
        if (hop_end.found) begin
          walk_res.status      = ST_OK;
          walk_res.slot_number = 6'(slot_w[SLOTS]);
        end else begin
          walk_res.status = ST_FULL;
        end
      end
      FUNC_DELIVER: begin
        if (hop_end.found) begin
          walk_res.status      = ST_OK;
          walk_res.slot_number = 6'(slot_w[SLOTS]);
          walk_res.source_addr = item_q.remote_addr;
          walk_res.source_port = item_q.remote_port;
          walk_res.udp_length  = item_q.header_length - HDR_BYTES;
        end else begin
          walk_res.status = ST_REFUSED;
        end
      end
      FUNC_SEND: begin
        walk_res.slot_number = item_q.target_slot;
        if (hop_end.found && hop_end.port != 16'd0) begin
          walk_res.status      = ST_OK;
          walk_res.source_addr = hop_end.addr;
          walk_res.dest_addr   = item_q.remote_addr;
          walk_res.source_port = hop_end.port;
          walk_res.dest_port   = item_q.remote_port;
          walk_res.udp_length  = item_q.byte_count + HDR_BYTES;
        end else begin
          walk_res.status = ST_NOT_OPEN;
        end
      end
      default: begin
        walk_res.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    busy_d     = busy_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    if (pend_vld_q && (!out_vld_q || m_axis_tready)) begin
      out_d      = pend_q;
      out_vld_d  = 1'b1;
      pend_vld_d = 1'b0;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (acc) begin
      if (imm) begin
        pend_d     = imm_res;
        pend_vld_d = 1'b1;
      end else if (item_in.func != FUNC_NONE) begin
        busy_d = 1'b1;
      end
    end
    if (hop_end.vld) begin
      pend_d     = walk_res;
      pend_vld_d = 1'b1;
      busy_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      inj_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      inj_q      <= acc && !imm && item_in.func != FUNC_NONE;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (acc) begin
      item_q <= item_in;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {2'b00, 16'd0, out_q.udp_length, out_q.dest_port, out_q.source_port,
                          out_q.dest_addr, out_q.source_addr, out_q.slot_number};

endmodule

@@ tb/udp_port_demux_table_tb.sv @@
module udp_port_demux_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import udpdmx_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 300;

  class binding_tracker;
    logic [31:0] bound_addr [SLOTS];
    logic [15:0] bound_port [SLOTS];
    res_t        pending_results [$];
    int          errors;
    int          results_checked;
    int          status_seen [8];
    int          func_seen [4];

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        bound_addr[i] = '0;
        bound_port[i] = '0;
      end
      errors = 0;
      results_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (func_seen[i]) func_seen[i] = 0;
    endfunction

    function void note_word(item_t it);
      res_t r;
      int   hit;
      r = '0;
      hit = -1;
      func_seen[it.func]++;
      case (it.func)
        FUNC_OPEN: begin
          if (it.local_port == 16'd0) begin
            r.status = ST_RESERVED;
          end else begin
            for (int i = 0; i < SLOTS && hit < 0; i++) begin
              if (bound_port[i] == 16'd0) hit = i;
            end
            if (hit < 0) begin
              r.status = ST_FULL;
            end else begin
              bound_addr[hit] = it.local_addr;
              bound_port[hit] = it.local_port;
              r.status = ST_OK;
              r.slot_number = 6'(hit);
            end
          end
        end
        FUNC_DELIVER: begin
          if (it.byte_count < HDR_BYTES || it.header_length < HDR_BYTES) begin
            r.status = ST_SHORT;
          end else begin
            for (int i = 0; i < SLOTS && hit < 0; i++) begin
              if (bound_port[i] != 16'd0 && bound_port[i] == it.local_port &&
                  bound_addr[i] == it.local_addr) hit = i;
            end
            if (hit < 0) begin
              r.status = ST_REFUSED;
            end else begin
              r.status = ST_OK;
              r.slot_number = 6'(hit);
              r.source_addr = it.remote_addr;
              r.source_port = it.remote_port;
              r.udp_length = it.header_length - HDR_BYTES;
            end
          end
        end
        FUNC_SEND: begin
          r.slot_number = it.target_slot;
          if (bound_port[it.target_slot] == 16'd0) begin
            r.status = ST_NOT_OPEN;
          end else begin
            r.status = ST_OK;
            r.source_addr = bound_addr[it.target_slot];
            r.dest_addr = it.remote_addr;
            r.source_port = bound_port[it.target_slot];
            r.dest_port = it.remote_port;
            r.udp_length = it.byte_count + HDR_BYTES;
          end
        end
        default: return;
      endcase
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(logic [135:0] data, logic [2:0] user);
      res_t r;
      status_seen[user]++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected nothing, got status %0d data %h",
                 $time, user, data);
        return;
      end
      r = pending_results.pop_front();
      results_checked++;
      compare_field("status", 32'(r.status), 32'(user));
      compare_field("slot_number", 32'(r.slot_number), 32'(data[5:0]));
      compare_field("source_addr", r.source_addr, data[37:6]);
      compare_field("dest_addr", r.dest_addr, data[69:38]);
      compare_field("source_port", 32'(r.source_port), 32'(data[85:70]));
      compare_field("dest_port", 32'(r.dest_port), 32'(data[101:86]));
      compare_field("udp_length", 32'(r.udp_length), 32'(data[117:102]));
      compare_field("checksum", 32'd0, 32'(data[133:118]));
      compare_field("pad", 32'd0, 32'(data[135:134]));
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  binding_tracker sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int holdoff_left = 0;
  bit holdoff_req = 1'b0;

  udp_port_demux_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Timeout: no word moved for %0d cycles at %0t.", QUIET_LIMIT, $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic item_t mk_item(func_e f, logic [31:0] laddr, logic [15:0] lport,
                                    logic [31:0] raddr, logic [15:0] rport,
                                    logic [15:0] cnt, logic [15:0] hlen, logic [5:0] slot);
    item_t it;
    it.func = f;
    it.local_addr = laddr;
    it.local_port = lport;
    it.remote_addr = raddr;
    it.remote_port = rport;
    it.byte_count = cnt;
    it.header_length = hlen;
    it.target_slot = slot;
    return it;
  endfunction

  function automatic item_t make_random_item();
    item_t it;
    int    open_ids [$];
    int    roll;
    int    pick;
    it = mk_item(func_e'($urandom_range(0, 2)), $urandom, 16'($urandom), $urandom,
                 16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
    for (int i = 0; i < SLOTS; i++) begin
      if (sb.bound_port[i] != 16'd0) open_ids.push_back(i);
    end
    pick = (open_ids.size() != 0) ? open_ids[$urandom_range(0, open_ids.size() - 1)] : 0;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      it.func = FUNC_OPEN;
      if ($urandom_range(0, 9) == 0) begin
        it.local_port = 16'd0;
      end else if (open_ids.size() != 0 && $urandom_range(0, 3) == 0) begin
        it.local_addr = sb.bound_addr[pick];
        it.local_port = sb.bound_port[pick];
      end else if (it.local_port == 16'd0) begin
        it.local_port = 16'd1;
      end
    end else if (roll < 52) begin
      it.func = FUNC_DELIVER;
      it.byte_count = 16'($urandom_range(8, 65535));
      it.header_length = ($urandom_range(0, 9) == 0) ? HDR_BYTES :
                         16'($urandom_range(8, 65535));
      if (open_ids.size() != 0) begin
        it.local_addr = sb.bound_addr[pick];
        it.local_port = sb.bound_port[pick];
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            it.local_addr = it.local_addr ^ (32'd1 << $urandom_range(0, 31));
          end else begin
            it.local_port = it.local_port ^ (16'd1 << $urandom_range(0, 15));
          end
        end
      end
    end else if (roll < 60) begin
      it.func = FUNC_DELIVER;
      if ($urandom_range(0, 1) == 0) begin
        it.byte_count = 16'($urandom_range(0, 7));
      end else begin
        it.header_length = 16'($urandom_range(0, 7));
      end
    end else if (roll < 88) begin
      it.func = FUNC_SEND;
      if (open_ids.size() != 0 && $urandom_range(0, 4) != 0) it.target_slot = 6'(pick);
    end else if (roll < 93) begin
      it.func = FUNC_NONE;
    end
    return it;
  endfunction

  task automatic send_word(input item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, it.target_slot, it.header_length, it.byte_count, it.remote_port,
                     it.remote_addr, it.local_port, it.local_addr};
    s_axis_tuser <= it.func;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(it);
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    item_t directed [$];
    item_t it;
    int    counted;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The table is empty here, so the sends and deliveries before the first open see only free slots.
    directed.push_back(mk_item(FUNC_SEND, '0, '0, '1, '1, '1, '0, 6'd0));
    directed.push_back(mk_item(FUNC_SEND, '0, '0, '0, '0, '0, '0, 6'd63));
    directed.push_back(mk_item(FUNC_DELIVER, '0, '0, '1, '1, 16'd8, 16'd8, '0));
    directed.push_back(mk_item(FUNC_DELIVER, '1, '1, '1, '1, 16'd7, '1, '1));
    directed.push_back(mk_item(FUNC_DELIVER, '1, '1, '1, '1, '1, 16'd7, '1));
    directed.push_back(mk_item(FUNC_DELIVER, '0, '0, '0, '0, '0, '0, '0));
    directed.push_back(mk_item(FUNC_OPEN, '1, '0, '1, '1, '1, '1, '1));
    directed.push_back(mk_item(FUNC_OPEN, '1, '1, '0, '0, '0, '0, '0));
    directed.push_back(mk_item(FUNC_OPEN, '0, 16'd1, '1, '1, '1, '1, '1));
    directed.push_back(mk_item(FUNC_OPEN, '1, '1, '0, '0, '0, '0, '0));
    directed.push_back(mk_item(FUNC_DELIVER, '1, '1, '1, '1, '1, '1, '0));
    directed.push_back(mk_item(FUNC_DELIVER, '0, 16'd1, '0, '0, 16'd8, 16'd8, '0));
    directed.push_back(mk_item(FUNC_DELIVER, '0, '0, '0, '0, 16'd8, 16'd8, '0));
    directed.push_back(mk_item(FUNC_DELIVER, 32'hFFFF_FFFE, '1, '1, '1, '1, '1, '0));
    directed.push_back(mk_item(FUNC_SEND, '0, '0, '1, '1, '1, '1, 6'd0));
    directed.push_back(mk_item(FUNC_SEND, '1, '1, '0, '0, '0, '0, 6'd1));
    directed.push_back(mk_item(FUNC_SEND, '0, '0, '1, '1, '1, '1, 6'd3));
    directed.push_back(mk_item(FUNC_NONE, '1, '1, '1, '1, '1, '1, '1));
    directed.push_back(mk_item(FUNC_SEND, '0, '0, '1, '0, 16'hFFF8, '0, 6'd2));
    directed.push_back(mk_item(FUNC_DELIVER, '1, '1, '0, '0, 16'd8, 16'd9, '1));
    foreach (directed[i]) send_word(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      wait_all_results();
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 79; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 79; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (ph == 0 && counted == PHASE_ITEMS / 2) holdoff_req = 1'b1;
        it = make_random_item();
        send_word(it);
        if (it.func != FUNC_NONE) counted++;
      end
    end

    wait_all_results();
    repeat (3 * SLOTS) @(posedge clk_i);

    $display("Words accepted: open %0d, deliver %0d, send %0d, unused %0d; results checked %0d.",
             sb.func_seen[FUNC_OPEN], sb.func_seen[FUNC_DELIVER], sb.func_seen[FUNC_SEND],
             sb.func_seen[FUNC_NONE], sb.results_checked);
    $display("Status tally: ok %0d, reserved %0d, full %0d, short %0d, refused %0d, not open %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_RESERVED], sb.status_seen[ST_FULL],
             sb.status_seen[ST_SHORT], sb.status_seen[ST_REFUSED], sb.status_seen[ST_NOT_OPEN]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/udpdmx_pkg.sv
design/udpdmx_cell.sv
design/udp_port_demux_table.sv
tb/udp_port_demux_table_tb.sv
